### rtl/snmp_request_header_parser_core_defines.svh
// assertion macros used by the port checker file
`ifndef SNMP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH
`define SNMP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH

// checked only while out of reset
`define SRHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SRHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srhp_pkg.sv
// types and constants of the snmp request header parser
package srhp_pkg;

    localparam int unsigned OID_KEEP  = 11;
    localparam int unsigned POS_W     = 13;
    localparam logic [POS_W-1:0] POS_SAT = 13'd4096;
    localparam int unsigned OUT_W     = 64;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] OID_ISO_ORG  = 8'h2B;
    localparam logic [7:0] ENT_HI       = 8'h82;
    localparam logic [7:0] ENT_MID      = 8'h9D;
    localparam logic [7:0] ENT_LO       = 8'h66;
    localparam logic [6:0] ANALOG_BASE  = 7'd16;
    localparam logic [6:0] DIGITAL_BASE = 7'd64;

    typedef enum logic [1:0] {
        CFG_COMMUNITY_TEXT   = 2'd0,
        CFG_COMMUNITY_LENGTH = 2'd1,
        CFG_MAX_VERSION      = 2'd2,
        CFG_MAX_PACKET_LEN   = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_GENERAL   = 3'd2,
        ST_COMMUNITY = 3'd3,
        ST_OID_LEN   = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        PH_SEQ_TAG, PH_SEQ_LEN, PH_VER_TAG, PH_VER_LEN, PH_VER_VAL,
        PH_COM_TAG, PH_COM_LEN, PH_COM_BYTES, PH_PDU_TAG, PH_PDU_LEN,
        PH_RID_TAG, PH_RID_LEN, PH_RID_BYTES, PH_ERR_TAG, PH_ERR_LEN,
        PH_ERR_BYTES, PH_EIX_TAG, PH_EIX_LEN, PH_EIX_BYTES, PH_VBL_TAG,
        PH_VBL_LEN, PH_VB_TAG, PH_VB_LEN, PH_OID_TAG, PH_OID_LEN,
        PH_OID_BYTES, PH_TAIL
    } t_phase;

    typedef struct packed {
        logic [63:0] community_text;
        logic [3:0]  community_length;
        logic [7:0]  max_version;
        logic [11:0] max_packet_length;
    } t_cfg;

    // header state as it stands after the last byte of a request
    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic                     at_tail;
        logic [7:0]               seq_len;
        t_status                  err;
        logic [7:0]               pdu;
        logic [31:0]              id;
        logic [7:0]               oid_len;
        logic [OID_KEEP-1:0][7:0] oid;
    } t_snap;

endpackage

### rtl/srhp_walker.sv
// byte walker over the ber headers of a request
module srhp_walker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    input  srhp_pkg::t_cfg   i_cfg,
    output srhp_pkg::t_snap  o_snap
);

    logic [srhp_pkg::POS_W-1:0]         r_pos, n_pos;
    srhp_pkg::t_phase                   r_phase, n_phase;
    logic [7:0]                         r_remaining, n_remaining;
    logic [7:0]                         r_seq_len, n_seq_len;
    srhp_pkg::t_status                  r_err, n_err;
    logic [7:0]                         r_pdu, n_pdu;
    logic [31:0]                        r_id, n_id;
    logic [7:0]                         r_oid_len, n_oid_len;
    logic [srhp_pkg::OID_KEEP-1:0][7:0] r_oid, n_oid;
    logic [3:0]                         r_com_index, n_com_index;

    logic [7:0] w_want;
    logic [7:0] w_rem_dec;
    logic [7:0] w_oid_idx;

    assign w_want    = i_cfg.community_text[{3'd7 - r_com_index[2:0], 3'b000} +: 8];
    assign w_rem_dec = (r_remaining != 8'd0) ? r_remaining - 8'd1 : 8'd0;
    assign w_oid_idx = r_oid_len - r_remaining;

    always_comb begin
        n_pos       = (r_pos < srhp_pkg::POS_SAT) ? r_pos + 1'b1 : r_pos;
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_seq_len   = r_seq_len;
        n_err       = r_err;
        n_pdu       = r_pdu;
        n_id        = r_id;
        n_oid_len   = r_oid_len;
        n_oid       = r_oid;
        n_com_index = r_com_index;
        unique case (r_phase)
            srhp_pkg::PH_SEQ_TAG: begin
                if (i_data != srhp_pkg::TAG_SEQUENCE) n_err = srhp_pkg::ST_GENERAL;
                n_phase = srhp_pkg::PH_SEQ_LEN;
            end
            srhp_pkg::PH_SEQ_LEN: begin
                n_seq_len = i_data;
                n_phase   = srhp_pkg::PH_VER_TAG;
            end
            srhp_pkg::PH_VER_TAG: n_phase = srhp_pkg::PH_VER_LEN;
            srhp_pkg::PH_VER_LEN: n_phase = srhp_pkg::PH_VER_VAL;
            srhp_pkg::PH_VER_VAL: begin
                if (i_data > i_cfg.max_version) n_err = srhp_pkg::ST_GENERAL;
                n_phase = srhp_pkg::PH_COM_TAG;
            end
            srhp_pkg::PH_COM_TAG: n_phase = srhp_pkg::PH_COM_LEN;
            srhp_pkg::PH_COM_LEN: begin
                if ((i_data != {4'd0, i_cfg.community_length} ||
                     i_cfg.community_length > 4'd8) && r_err == srhp_pkg::ST_OK)
                    n_err = srhp_pkg::ST_COMMUNITY;
                n_com_index = 4'd0;
                n_remaining = i_data;
                n_phase     = (i_data == 8'd0) ? srhp_pkg::PH_PDU_TAG
                                               : srhp_pkg::PH_COM_BYTES;
            end
            srhp_pkg::PH_COM_BYTES: begin
                if (r_err == srhp_pkg::ST_OK &&
                    (r_com_index >= 4'd8 || w_want != i_data))
                    n_err = srhp_pkg::ST_COMMUNITY;
                if (r_com_index < 4'd8) n_com_index = r_com_index + 4'd1;
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) n_phase = srhp_pkg::PH_PDU_TAG;
            end
            srhp_pkg::PH_PDU_TAG: begin
                n_pdu   = i_data;
                n_phase = srhp_pkg::PH_PDU_LEN;
            end
            srhp_pkg::PH_PDU_LEN: n_phase = srhp_pkg::PH_RID_TAG;
            srhp_pkg::PH_RID_TAG: n_phase = srhp_pkg::PH_RID_LEN;
            srhp_pkg::PH_RID_LEN: begin
                n_remaining = i_data;
                n_phase     = (i_data == 8'd0) ? srhp_pkg::PH_ERR_TAG
                                               : srhp_pkg::PH_RID_BYTES;
            end
            srhp_pkg::PH_RID_BYTES: begin
                n_id        = {r_id[23:0], i_data};
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) n_phase = srhp_pkg::PH_ERR_TAG;
            end
            srhp_pkg::PH_ERR_TAG: n_phase = srhp_pkg::PH_ERR_LEN;
            srhp_pkg::PH_ERR_LEN: begin
                n_remaining = i_data;
                n_phase     = (i_data == 8'd0) ? srhp_pkg::PH_EIX_TAG
                                               : srhp_pkg::PH_ERR_BYTES;
            end
            srhp_pkg::PH_ERR_BYTES: begin
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) n_phase = srhp_pkg::PH_EIX_TAG;
            end
            srhp_pkg::PH_EIX_TAG: n_phase = srhp_pkg::PH_EIX_LEN;
            srhp_pkg::PH_EIX_LEN: begin
                n_remaining = i_data;
                n_phase     = (i_data == 8'd0) ? srhp_pkg::PH_VBL_TAG
                                               : srhp_pkg::PH_EIX_BYTES;
            end
            srhp_pkg::PH_EIX_BYTES: begin
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) n_phase = srhp_pkg::PH_VBL_TAG;
            end
            srhp_pkg::PH_VBL_TAG: n_phase = srhp_pkg::PH_VBL_LEN;
            srhp_pkg::PH_VBL_LEN: n_phase = srhp_pkg::PH_VB_TAG;
            srhp_pkg::PH_VB_TAG:  n_phase = srhp_pkg::PH_VB_LEN;
            srhp_pkg::PH_VB_LEN:  n_phase = srhp_pkg::PH_OID_TAG;
            srhp_pkg::PH_OID_TAG: n_phase = srhp_pkg::PH_OID_LEN;
            srhp_pkg::PH_OID_LEN: begin
                n_oid_len   = i_data;
                n_remaining = i_data;
                n_phase     = (i_data == 8'd0) ? srhp_pkg::PH_TAIL
                                               : srhp_pkg::PH_OID_BYTES;
            end
            srhp_pkg::PH_OID_BYTES: begin
                for (int i = 0; i < srhp_pkg::OID_KEEP; i++) begin
                    if (w_oid_idx == 8'(i)) n_oid[i] = i_data;
                end
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) n_phase = srhp_pkg::PH_TAIL;
            end
            default: n_phase = srhp_pkg::PH_TAIL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos       <= '0;
            r_phase     <= srhp_pkg::PH_SEQ_TAG;
            r_remaining <= '0;
            r_seq_len   <= '0;
            r_err       <= srhp_pkg::ST_OK;
            r_pdu       <= '0;
            r_id        <= '0;
            r_oid_len   <= '0;
            r_oid       <= '0;
            r_com_index <= '0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_seq_len   <= n_seq_len;
            r_err       <= n_err;
            r_pdu       <= n_pdu;
            r_id        <= n_id;
            r_oid_len   <= n_oid_len;
            r_oid       <= n_oid;
            r_com_index <= n_com_index;
        end
    end

    always_comb begin
        o_snap.pos     = n_pos;
        o_snap.at_tail = (n_phase == srhp_pkg::PH_TAIL);
        o_snap.seq_len = n_seq_len;
        o_snap.err     = n_err;
        o_snap.pdu     = n_pdu;
        o_snap.id      = n_id;
        o_snap.oid_len = n_oid_len;
        o_snap.oid     = n_oid;
    end

endmodule

### rtl/srhp_result.sv
// status, oid class and the output register with skid stage
module srhp_result #(
    parameter int unsigned MAX_OID_BYTES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  srhp_pkg::t_snap            i_snap,
    input  logic [11:0]                i_max_packet_length,
    input  logic                       i_tready,
    output logic                       o_tvalid,
    output logic [srhp_pkg::OUT_W-1:0] o_tdata,
    output logic                       o_skid_full
);

    localparam logic [7:0] OID_MAX = 8'(MAX_OID_BYTES);
    localparam int unsigned REC_W  = 3 + 8 + 32 + 8 + 7;

    srhp_pkg::t_status w_status;
    logic [6:0]        w_class;
    logic [REC_W-1:0]  w_rec;
    logic              w_pop;

    logic              r_out_valid;
    logic [REC_W-1:0]  r_out_rec;
    logic              r_skid_valid;
    logic [REC_W-1:0]  r_skid_rec;

    always_comb begin
        if ({3'd0, i_snap.pos} > {4'd0, i_max_packet_length} + 16'd0)
            w_status = srhp_pkg::ST_TOO_BIG;
        else if (i_snap.err == srhp_pkg::ST_GENERAL || !i_snap.at_tail ||
                 i_snap.pos < 13'd2 || (i_snap.pos - 13'd2) != {5'd0, i_snap.seq_len})
            w_status = srhp_pkg::ST_GENERAL;
        else if (i_snap.err == srhp_pkg::ST_COMMUNITY)
            w_status = srhp_pkg::ST_COMMUNITY;
        else if (i_snap.oid_len == 8'd0 || i_snap.oid_len > OID_MAX)
            w_status = srhp_pkg::ST_OID_LEN;
        else
            w_status = srhp_pkg::ST_OK;
    end

    // general group .1.3.6.1.2.1.1.x.0, enterprise groups .1.3.6.1.4.1.e.{1,2}.x.0
    always_comb begin
        w_class = 7'd0;
        if (w_status == srhp_pkg::ST_OK &&
            i_snap.oid[0] == srhp_pkg::OID_ISO_ORG && i_snap.oid[1] == 8'h06 &&
            i_snap.oid[2] == 8'h01) begin
            if (i_snap.oid[3] == 8'h02 && i_snap.oid[4] == 8'h01 &&
                i_snap.oid[5] == 8'h01 && i_snap.oid[7] == 8'h00) begin
                if (i_snap.oid[6] >= 8'd1 && i_snap.oid[6] <= 8'd6)
                    w_class = i_snap.oid[6][6:0];
            end else if (i_snap.oid[3] == 8'h04 && i_snap.oid[4] == 8'h01 &&
                         i_snap.oid[5] == srhp_pkg::ENT_HI &&
                         i_snap.oid[6] == srhp_pkg::ENT_MID &&
                         i_snap.oid[7] == srhp_pkg::ENT_LO &&
                         i_snap.oid[10] == 8'h00 &&
                         i_snap.oid[9] >= 8'd1 && i_snap.oid[9] <= 8'd16) begin
                if (i_snap.oid[8] == 8'h01)
                    w_class = i_snap.oid[9][6:0] + srhp_pkg::ANALOG_BASE;
                else if (i_snap.oid[8] == 8'h02)
                    w_class = i_snap.oid[9][6:0] + srhp_pkg::DIGITAL_BASE;
            end
        end
    end

    assign w_rec = {w_class, i_snap.oid_len, i_snap.id, i_snap.pdu, w_status};
    assign w_pop = r_out_valid && i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out_rec    <= r_skid_rec;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_rec   <= w_rec;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_rec   <= w_rec;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tvalid    = r_out_valid;
    assign o_tdata     = {{(srhp_pkg::OUT_W - REC_W){1'b0}}, r_out_rec};
    assign o_skid_full = r_skid_valid;

endmodule

### rtl/snmp_request_header_parser_core.sv
// top level of the snmp request header parser
//
// requests arrive one byte per beat on the s_axis channel, tlast on the final
// byte. one result per request leaves on m_axis when that final byte has been
// taken; bytes that are not last give nothing.
// s_axis_tdata: data_byte. m_axis_tdata from bit 0 up: status[2:0],
// pdu_type[10:3], request_id[42:11], oid_length[50:43], oid_class[57:51], zeros.
// a byte is taken every cycle while s_axis_tready is high; the header walker
// and the status and class logic sit between the walker registers and the
// output register, so a result lands there, or in the skid stage if stalled.
// the output register is backed by a one-entry skid stage: while the receiver
// stalls, bytes are still taken until a second result waits, then tready drops
// until the receiver takes one. the user writes configuration through
// i_cfg_we, i_cfg_index and i_cfg_wdata only while no request is in flight;
// the block does not enforce this. reset empties the output, clears the walker
// and loads the register defaults (version limit 1, packet limit 484 bytes).
module snmp_request_header_parser_core #(
    parameter int unsigned MAX_OID_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // status, pdu_type, request_id, oid_length, oid_class
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    srhp_pkg::t_cfg  r_cfg;
    srhp_pkg::t_snap w_snap;
    logic            w_accept;
    logic            w_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.community_text    <= '0;
            r_cfg.community_length  <= '0;
            r_cfg.max_version       <= 8'd1;
            r_cfg.max_packet_length <= 12'd484;
        end else if (i_cfg_we) begin
            unique case (srhp_pkg::t_cfg_index'(i_cfg_index))
                srhp_pkg::CFG_COMMUNITY_TEXT:   r_cfg.community_text    <= i_cfg_wdata;
                srhp_pkg::CFG_COMMUNITY_LENGTH: r_cfg.community_length  <= i_cfg_wdata[3:0];
                srhp_pkg::CFG_MAX_VERSION:      r_cfg.max_version       <= i_cfg_wdata[7:0];
                srhp_pkg::CFG_MAX_PACKET_LEN:   r_cfg.max_packet_length <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = i_rst_n && !w_skid_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    srhp_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_cfg    (r_cfg),
        .o_snap   (w_snap)
    );

    srhp_result #(
        .MAX_OID_BYTES (MAX_OID_BYTES)
    ) u_result (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (w_accept && s_axis_tlast),
        .i_snap              (w_snap),
        .i_max_packet_length (r_cfg.max_packet_length),
        .i_tready            (m_axis_tready),
        .o_tvalid            (m_axis_tvalid),
        .o_tdata             (m_axis_tdata),
        .o_skid_full         (w_skid_full)
    );

endmodule

### rtl/srhp_checker.sv
// port checker for the snmp request header parser, bound to the top level
`include "snmp_request_header_parser_core_defines.svh"

module srhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    `SRHP_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")
    `SRHP_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `SRHP_ASSERT(a_status_code, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[2:0] <= srhp_pkg::ST_OID_LEN, "unknown status")
    `SRHP_ASSERT(a_class_on_error, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] != srhp_pkg::ST_OK |-> m_axis_tdata[57:51] == 7'd0, "class on failed request")
    `SRHP_ASSERT(a_result_from_last, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast), "result without last byte")

endmodule

bind snmp_request_header_parser_core srhp_checker u_srhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
